// ----- rtl/core/rgbhsl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// shared types, constants and the divider step for the rgb to hsl converter
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int QUOT_W  = 16;
    localparam int DIVR_W  = 9;
    localparam int NUMR_W  = QUOT_W + DIVR_W;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [8:0]  HUE_COEF_GREEN = 9'd120;
    localparam logic [8:0]  HUE_COEF_BLUE  = 9'd240;
    localparam logic [8:0]  HUE_COEF_WRAP  = 9'd360;
    localparam logic [5:0]  DEG_PER_SECTOR = 6'd60;
    localparam logic [16:0] SAT_SCALE      = 17'd131070;
    localparam logic [8:0]  SUM_FULL       = 9'd510;
    localparam logic [15:0] HUE_FULL       = 16'd360;

    // one row of the divider pipeline: two restoring dividers side by side
    typedef struct packed {
        logic [DIVR_W-1:0] hrem;
        logic [QUOT_W-1:0] hsh;
        logic [DIVR_W-1:0] hdiv;
        logic [DIVR_W-1:0] srem;
        logic [QUOT_W-1:0] ssh;
        logic [DIVR_W-1:0] sdiv;
        logic [8:0]        sum;
        logic [7:0]        alpha;
        logic              grey;
        logic              flat;
    } div_stage_t;

    // one quotient bit; the shift register turns from dividend into quotient
    function automatic logic [DIVR_W+QUOT_W-1:0] div_bit(
        input logic [DIVR_W-1:0] rem,
        input logic [QUOT_W-1:0] sh,
        input logic [DIVR_W-1:0] dv
    );
        logic [DIVR_W:0]   t;
        logic              ge;
        logic [DIVR_W-1:0] r;
        t  = {rem, sh[QUOT_W-1]};
        ge = (t >= {1'b0, dv});
        r  = ge ? DIVR_W'(t - {1'b0, dv}) : t[DIVR_W-1:0];
        return {r, sh[QUOT_W-2:0], ge};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rgbhsl_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_pix_if
// rgba pixel channel with valid / ready
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_in;

    modport source (output valid, output red, output green, output blue,
                    output alpha_in, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rgbhsl_hsl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_hsl_if
// hsl result channel with valid / ready
// ----------------------------------------------------------------------------
interface rgbhsl_hsl_if;
    logic        valid;
    logic        ready;
    logic [8:0]  hue;
    logic [15:0] saturation;
    logic [8:0]  lightness_sum;
    logic [7:0]  alpha_out;

    modport source (output valid, output hue, output saturation,
                    output lightness_sum, output alpha_out, input ready);
    modport sink   (input valid, input hue, input saturation,
                    input lightness_sum, input alpha_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rgb_to_hsl_pixel_convert_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_convert_core
// rgba pixel to hue / saturation / lightness sum; while ready is high, one pixel per clock
// ----------------------------------------------------------------------------
// usage:
//   pix carries red, green, blue and alpha_in; hsl returns hue (degrees),
//   saturation (q0.16), lightness_sum (max + min) and alpha_out
//   a transaction completes on a rising edge with valid and ready both high
//   path: a pixel passes through nineteen register stages: two front
//   stages, sixteen divider stages (one quotient bit each) and the
//   output register
//   throughput: one pixel per clock while the receiver keeps ready high;
//   the sixteen-stage divider sets the latency, not the rate
//   when the receiver stalls the whole pipeline holds and pix.ready drops
//   only while a finished result waits; nothing is lost or repeated
//   reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_convert_core
    import rgbhsl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rgbhsl_pix_if.sink    pix,
    rgbhsl_hsl_if.source  hsl
);

    logic       en;
    logic       front_valid;
    div_stage_t front_stage;
    logic       div_valid;
    div_stage_t div_stage;

    logic        out_valid_reg;
    logic [8:0]  hue_reg;
    logic [15:0] sat_reg;
    logic [8:0]  sum_reg;
    logic [7:0]  alpha_reg;
    logic [8:0]  hue_next;
    logic [15:0] sat_next;

    assign en        = !out_valid_reg || hsl.ready;
    assign pix.ready = en;

    rgbhsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix.valid),
        .red       (pix.red),
        .green     (pix.green),
        .blue      (pix.blue),
        .alpha_in  (pix.alpha_in),
        .out_valid (front_valid),
        .out_stage (front_stage)
    );

    rgbhsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_stage  (front_stage),
        .out_valid (div_valid),
        .out_stage (div_stage)
    );

    // hue rounding can reach 360, which wraps to 0
    always_comb
    begin
        if (div_stage.grey)
            hue_next = 9'd0;
        else if (div_stage.hsh >= HUE_FULL)
            hue_next = 9'(div_stage.hsh - HUE_FULL);
        else
            hue_next = div_stage.hsh[8:0];
        sat_next = div_stage.flat ? 16'd0 : div_stage.ssh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            sum_reg   <= div_stage.sum;
            alpha_reg <= div_stage.alpha;
        end
    end

    assign hsl.valid         = out_valid_reg;
    assign hsl.hue           = hue_reg;
    assign hsl.saturation    = sat_reg;
    assign hsl.lightness_sum = sum_reg;
    assign hsl.alpha_out     = alpha_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl.valid |-> (hsl.hue < 9'd360))
        else $error("hue out of range");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl.valid |-> (hsl.lightness_sum <= SUM_FULL))
        else $error("lightness sum out of range");

    a_sat_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl.valid && (hsl.lightness_sum == 9'd0 || hsl.lightness_sum == SUM_FULL))
        |-> (hsl.saturation == 16'd0))
        else $error("saturation nonzero for black or white");

endmodule
`default_nettype wire

// ----- rtl/core/rgbhsl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_front
// two stages: max / min and sector, then the hue and saturation dividends
// ----------------------------------------------------------------------------
module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [7:0] alpha_in,
    output      logic       out_valid,
    output      div_stage_t out_stage
);

    logic       a_valid_reg;
    logic [7:0] a_c_reg;
    logic [8:0] a_sum_reg;
    logic [1:0] a_sec_reg;
    logic       a_neg_reg;
    logic [7:0] a_dm_reg;
    logic [7:0] a_alpha_reg;

    logic       b_valid_reg;
    div_stage_t b_stage_reg;

    logic [7:0] mx, mn, dp, dn;
    logic [1:0] sec;
    logic       neg;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        if (red >= green && red >= blue)
        begin
            sec = SEC_RED;
            dp  = green;
            dn  = blue;
        end
        else if (green >= blue)
        begin
            sec = SEC_GREEN;
            dp  = blue;
            dn  = red;
        end
        else
        begin
            sec = SEC_BLUE;
            dp  = red;
            dn  = green;
        end
        neg = dp < dn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_c_reg     <= mx - mn;
            a_sum_reg   <= {1'b0, mx} + {1'b0, mn};
            a_sec_reg   <= sec;
            a_neg_reg   <= neg;
            a_dm_reg    <= neg ? dn - dp : dp - dn;
            a_alpha_reg <= alpha_in;
        end
    end

    logic [8:0]        coef;
    logic [16:0]       base;
    logic [13:0]       sixty;
    logic [16:0]       num;
    logic [17:0]       hue_num;
    logic [7:0]        den;
    logic [24:0]       sat_num;
    logic [NUMR_W-1:0] hue_ext;
    div_stage_t        b_stage_next;

    always_comb
    begin
        unique case (a_sec_reg)
            SEC_RED:   coef = a_neg_reg ? HUE_COEF_WRAP : 9'd0;
            SEC_GREEN: coef = HUE_COEF_GREEN;
            SEC_BLUE:  coef = HUE_COEF_BLUE;
            default:   coef = 9'd0;
        endcase
        base    = {8'b0, coef} * {9'b0, a_c_reg};
        sixty   = {6'b0, a_dm_reg} * {8'b0, DEG_PER_SECTOR};
        num     = a_neg_reg ? base - {3'b0, sixty} : base + {3'b0, sixty};
        hue_num = {num, 1'b0} + {10'b0, a_c_reg};
        den     = (a_sum_reg <= 9'd255) ? a_sum_reg[7:0] : 8'(SUM_FULL - a_sum_reg);
        sat_num = {17'b0, a_c_reg} * {8'b0, SAT_SCALE} + {17'b0, den};
        hue_ext = {7'b0, hue_num};

        b_stage_next.hrem  = hue_ext[NUMR_W-1:QUOT_W];
        b_stage_next.hsh   = hue_ext[QUOT_W-1:0];
        b_stage_next.hdiv  = {a_c_reg, 1'b0};
        b_stage_next.srem  = sat_num[NUMR_W-1:QUOT_W];
        b_stage_next.ssh   = sat_num[QUOT_W-1:0];
        b_stage_next.sdiv  = {den, 1'b0};
        b_stage_next.sum   = a_sum_reg;
        b_stage_next.alpha = a_alpha_reg;
        b_stage_next.grey  = (a_c_reg == 8'd0);
        b_stage_next.flat  = (den == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            b_stage_reg <= b_stage_next;
    end

    assign out_valid = b_valid_reg;
    assign out_stage = b_stage_reg;

endmodule
`default_nettype wire

// ----- rtl/core/rgbhsl_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_div
// pipelined restoring division, one quotient bit per stage, hue and
// saturation lanes in step
// ----------------------------------------------------------------------------
module rgbhsl_div
    import rgbhsl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire div_stage_t in_stage,
    output      logic       out_valid,
    output      div_stage_t out_stage
);

    div_stage_t       stage_d   [0:QUOT_W];
    logic [QUOT_W:0]  valid_d;
    div_stage_t       stage_reg [0:QUOT_W-1];
    logic [QUOT_W-1:0] valid_reg;

    assign stage_d[0] = in_stage;
    assign valid_d[0] = in_valid;

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_step
        div_stage_t stage_next;

        always_comb
        begin
            stage_next = stage_d[k];
            {stage_next.hrem, stage_next.hsh} =
                div_bit(stage_d[k].hrem, stage_d[k].hsh, stage_d[k].hdiv);
            {stage_next.srem, stage_next.ssh} =
                div_bit(stage_d[k].srem, stage_d[k].ssh, stage_d[k].sdiv);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_d[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[k] <= stage_next;
        end

        assign stage_d[k+1] = stage_reg[k];
        assign valid_d[k+1] = valid_reg[k];
    end

    assign out_valid = valid_d[QUOT_W];
    assign out_stage = stage_d[QUOT_W];

endmodule
`default_nettype wire
